### src/bwt_pkg.sv
// Shared types and codes for the breakpoint and watchpoint table.
package bwt_pkg;

    localparam int ADDR_W_MAX = 24;

    localparam logic [2:0] OP_ADD_BP  = 3'd0;
    localparam logic [2:0] OP_ADD_WP  = 3'd1;
    localparam logic [2:0] OP_FIND_BP = 3'd2;
    localparam logic [2:0] OP_FIND_WP = 3'd3;
    localparam logic [2:0] OP_BP_ON   = 3'd4;
    localparam logic [2:0] OP_BP_OFF  = 3'd5;
    localparam logic [2:0] OP_WP_ON   = 3'd6;
    localparam logic [2:0] OP_WP_OFF  = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_PRESENT   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;

    localparam logic [1:0] KIND_RW = 2'd3;

    typedef struct packed {
        logic accept;
        logic cmp;
        logic dec;
        logic rd;
        logic wr;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic [2:0]            status;
        logic [4:0]            idx;
        logic [ADDR_W_MAX-1:0] rep;
        logic                  upd_exec;
        logic                  upd_read;
        logic                  upd_write;
        logic                  on;
    } t_dec;

endpackage

### src/bwt_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module bwt_ctrl import bwt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_m_tready,
    input  logic i_clr_done,
    output t_cmd o_cmd,
    output logic o_s_tready,
    output logic o_m_tvalid
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CMP, S_DEC, S_RD, S_WR} t_state;

    t_state r_state;
    logic   r_valid;

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.cmp    = (r_state == S_CMP);
        o_cmd.dec    = (r_state == S_DEC);
        o_cmd.rd     = (r_state == S_RD);
        o_cmd.wr     = (r_state == S_WR) && (!r_valid || i_m_tready);
        o_cmd.clr    = (r_state == S_CLEAR) && !i_clr_done;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            if (o_cmd.wr) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: if (i_clr_done) r_state <= S_IDLE;
                S_IDLE:  if (i_s_tvalid) r_state <= S_CMP;
                S_CMP:   r_state <= S_DEC;
                S_DEC:   r_state <= S_RD;
                S_RD:    r_state <= S_WR;
                S_WR:    if (o_cmd.wr) r_state <= S_IDLE;
                default: r_state <= S_CLEAR;
            endcase
        end
    end

endmodule

### src/bwt_table.sv
// Breakpoint and watchpoint tables with the search and the decision logic.
module bwt_table import bwt_pkg::*; #(
    parameter int TABLE_ENTRIES = 32,
    parameter int ADDRESS_BITS  = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_op,
    input  logic [19:0] i_address,
    input  logic [1:0]  i_watch_kind,
    input  logic [5:0]  i_slot,
    output t_dec        o_dec
);

    localparam int N  = TABLE_ENTRIES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);

    logic [2:0]              r_op;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [1:0]              r_kind;
    logic [5:0]              r_slot;

    logic [ADDRESS_BITS-1:0] r_bp_addr [N];
    logic [N-1:0]            r_bp_act;
    logic [CW-1:0]           r_bp_cnt;
    logic [ADDRESS_BITS-1:0] r_wp_addr [N];
    logic [1:0]              r_wp_kind [N];
    logic [N-1:0]            r_wp_act;
    logic [CW-1:0]           r_wp_cnt;

    logic [N-1:0]            r_bp_hit;
    logic [N-1:0]            r_wp_hit;
    logic [ADDRESS_BITS-1:0] r_sl_bp_addr;
    logic [ADDRESS_BITS-1:0] r_sl_wp_addr;
    logic [1:0]              r_sl_kind;
    t_dec                    r_dec;
    t_dec                    n_dec;

    logic [IW-1:0] slot_idx;
    logic [IW-1:0] bp_idx;
    logic [IW-1:0] wp_idx;
    logic [1:0]    need;
    logic          bp_slot_ok;
    logic          wp_slot_ok;

    assign slot_idx   = IW'(r_slot[4:0]);
    assign need       = (r_op == OP_ADD_WP) ? KIND_RW : r_kind;
    assign bp_slot_ok = int'(r_slot[4:0]) < int'(r_bp_cnt);
    assign wp_slot_ok = int'(r_slot[4:0]) < int'(r_wp_cnt);
    assign o_dec      = r_dec;

    always_comb begin
        bp_idx = '0;
        wp_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (r_bp_hit[i]) bp_idx = IW'(i);
            if (r_wp_hit[i]) wp_idx = IW'(i);
        end
    end

    always_comb begin
        n_dec           = '0;
        n_dec.rep       = ADDR_W_MAX'(r_addr);
        unique case (r_op)
            OP_ADD_BP: begin
                if (int'(r_bp_cnt) >= N) begin
                    n_dec.status = ST_FULL;
                end else if (|r_bp_hit) begin
                    n_dec.status = ST_PRESENT;
                end else begin
                    n_dec.idx      = 5'(r_bp_cnt);
                    n_dec.upd_exec = 1'b1;
                    n_dec.on       = 1'b1;
                end
            end
            OP_ADD_WP: begin
                if (int'(r_wp_cnt) >= N) begin
                    n_dec.status = ST_FULL;
                end else if (|r_wp_hit) begin
                    n_dec.status = ST_PRESENT;
                end else begin
                    n_dec.idx       = 5'(r_wp_cnt);
                    n_dec.upd_read  = r_kind[0];
                    n_dec.upd_write = r_kind[1];
                    n_dec.on        = 1'b1;
                end
            end
            OP_FIND_BP: begin
                if (|r_bp_hit) n_dec.idx = 5'(bp_idx);
                else n_dec.status = ST_NOT_FOUND;
            end
            OP_FIND_WP: begin
                if (|r_wp_hit) n_dec.idx = 5'(wp_idx);
                else n_dec.status = ST_NOT_FOUND;
            end
            OP_BP_ON, OP_BP_OFF: begin
                if (r_slot[5]) begin
                    n_dec.status = ST_IGNORED;
                end else if (!bp_slot_ok) begin
                    n_dec.status = ST_NOT_FOUND;
                end else begin
                    n_dec.idx      = r_slot[4:0];
                    n_dec.rep      = ADDR_W_MAX'(r_sl_bp_addr);
                    n_dec.upd_exec = 1'b1;
                    n_dec.on       = (r_op == OP_BP_ON);
                end
            end
            OP_WP_ON, OP_WP_OFF: begin
                if (r_slot[5]) begin
                    n_dec.status = ST_IGNORED;
                end else if (!wp_slot_ok) begin
                    n_dec.status = ST_NOT_FOUND;
                end else begin
                    n_dec.idx       = r_slot[4:0];
                    n_dec.rep       = ADDR_W_MAX'(r_sl_wp_addr);
                    n_dec.upd_read  = r_sl_kind[0];
                    n_dec.upd_write = r_sl_kind[1];
                    n_dec.on        = (r_op == OP_WP_ON);
                end
            end
            default: n_dec.status = ST_IGNORED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_addr <= ADDRESS_BITS'(i_address);
            r_kind <= i_watch_kind;
            r_slot <= i_slot;
        end
        if (i_cmd.cmp) begin
            for (int i = 0; i < N; i++) begin
                r_bp_hit[i] <= r_bp_act[i] && (r_bp_addr[i] == r_addr);
                r_wp_hit[i] <= r_wp_act[i] && (r_wp_addr[i] == r_addr)
                               && ((r_wp_kind[i] & need) == need);
            end
            r_sl_bp_addr <= r_bp_addr[slot_idx];
            r_sl_wp_addr <= r_wp_addr[slot_idx];
            r_sl_kind    <= r_wp_kind[slot_idx];
        end
        if (i_cmd.dec) begin
            r_dec <= n_dec;
        end
        if (i_cmd.wr && (r_dec.status == ST_OK)) begin
            if (r_op == OP_ADD_BP) begin
                r_bp_addr[IW'(r_bp_cnt)] <= r_addr;
            end
            if (r_op == OP_ADD_WP) begin
                r_wp_addr[IW'(r_wp_cnt)] <= r_addr;
                r_wp_kind[IW'(r_wp_cnt)] <= r_kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp_act <= '0;
            r_wp_act <= '0;
            r_bp_cnt <= '0;
            r_wp_cnt <= '0;
        end else if (i_cmd.wr && (r_dec.status == ST_OK)) begin
            case (r_op)
                OP_ADD_BP: begin
                    r_bp_act[IW'(r_bp_cnt)] <= 1'b1;
                    r_bp_cnt <= r_bp_cnt + 1'b1;
                end
                OP_ADD_WP: begin
                    r_wp_act[IW'(r_wp_cnt)] <= 1'b1;
                    r_wp_cnt <= r_wp_cnt + 1'b1;
                end
                OP_BP_ON, OP_BP_OFF: r_bp_act[slot_idx] <= r_dec.on;
                OP_WP_ON, OP_WP_OFF: r_wp_act[slot_idx] <= r_dec.on;
                default: ;
            endcase
        end
    end

endmodule

### src/bwt_bitmap.sv
// Exec, read and write bitmaps with page summaries, and the result registers.
module bwt_bitmap import bwt_pkg::*; #(
    parameter int ADDRESS_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_dec        i_dec,
    output logic        o_clr_done,
    output logic [2:0]  o_status,
    output logic [4:0]  o_found_index,
    output logic [63:0] o_exec_word,
    output logic [63:0] o_read_word,
    output logic [63:0] o_write_word,
    output logic [63:0] o_read_exec_word,
    output logic [63:0] o_read_summary,
    output logic [63:0] o_write_summary
);

    localparam int WA = ADDRESS_BITS - 6;
    localparam int PA = ADDRESS_BITS - 12;
    localparam int PW = (PA > 0) ? PA : 1;
    localparam int NW = 1 << WA;
    localparam int NP = 1 << PW;

    logic [63:0] r_mem_exec  [NW];
    logic [63:0] r_mem_read  [NW];
    logic [63:0] r_mem_write [NW];
    logic [63:0] r_sum_read  [NP];
    logic [63:0] r_sum_write [NP];

    logic [WA:0] r_clr;
    logic [63:0] r_ex, r_rd, r_wr, r_sr, r_sw;
    logic [63:0] n_ex, n_rd, n_wr, n_sr, n_sw;
    logic [63:0] bit_m, sum_m;
    logic [WA-1:0] w_addr;
    logic [PW-1:0] p_addr;
    logic [WA-1:0] mw_addr;
    logic [PW-1:0] mp_addr;

    assign o_clr_done = r_clr[WA];
    assign w_addr  = i_dec.rep[ADDRESS_BITS-1:6];
    assign p_addr  = PW'(i_dec.rep[ADDRESS_BITS-1:6] >> 6);
    assign mw_addr = i_cmd.clr ? r_clr[WA-1:0] : w_addr;
    assign mp_addr = i_cmd.clr ? PW'(r_clr[WA-1:0]) : p_addr;
    assign bit_m   = 64'd1 << i_dec.rep[5:0];
    assign sum_m   = 64'd1 << i_dec.rep[11:6];

    always_comb begin
        n_ex = r_ex;
        n_rd = r_rd;
        n_wr = r_wr;
        n_sr = r_sr;
        n_sw = r_sw;
        if (i_dec.upd_exec) begin
            n_ex = i_dec.on ? (r_ex | bit_m) : (r_ex & ~bit_m);
        end
        if (i_dec.upd_read) begin
            n_rd = i_dec.on ? (r_rd | bit_m) : (r_rd & ~bit_m);
            if (i_dec.on) n_sr = r_sr | sum_m;
            else if (n_rd == '0) n_sr = r_sr & ~sum_m;
        end
        if (i_dec.upd_write) begin
            n_wr = i_dec.on ? (r_wr | bit_m) : (r_wr & ~bit_m);
            if (i_dec.on) n_sw = r_sw | sum_m;
            else if (n_wr == '0) n_sw = r_sw & ~sum_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || (i_cmd.wr && i_dec.upd_exec)) begin
            r_mem_exec[mw_addr] <= i_cmd.clr ? '0 : n_ex;
        end
        if (i_cmd.rd) r_ex <= r_mem_exec[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || (i_cmd.wr && i_dec.upd_read)) begin
            r_mem_read[mw_addr] <= i_cmd.clr ? '0 : n_rd;
        end
        if (i_cmd.rd) r_rd <= r_mem_read[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || (i_cmd.wr && i_dec.upd_write)) begin
            r_mem_write[mw_addr] <= i_cmd.clr ? '0 : n_wr;
        end
        if (i_cmd.rd) r_wr <= r_mem_write[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || (i_cmd.wr && i_dec.upd_read)) begin
            r_sum_read[mp_addr] <= i_cmd.clr ? '0 : n_sr;
        end
        if (i_cmd.rd) r_sr <= r_sum_read[p_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || (i_cmd.wr && i_dec.upd_write)) begin
            r_sum_write[mp_addr] <= i_cmd.clr ? '0 : n_sw;
        end
        if (i_cmd.rd) r_sw <= r_sum_write[p_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            o_status         <= i_dec.status;
            o_found_index    <= i_dec.idx;
            o_exec_word      <= n_ex;
            o_read_word      <= n_rd;
            o_write_word     <= n_wr;
            o_read_exec_word <= n_rd | n_ex;
            o_read_summary   <= n_sr;
            o_write_summary  <= n_sw;
        end
    end

endmodule

### src/breakpoint_watchpoint_table.sv
// Top level of the breakpoint and watchpoint table.
// After reset the block clears its bitmaps and page summaries, one word a cycle; no request is
// taken meanwhile. Each request then passes from acceptance to a loaded result through the
// table compare, the highest-slot decision, the bitmap read and the read-modify-write. One
// request is handled at a time; a result held by back-pressure stalls the read-modify-write of
// the next one, and a new request is taken in the cycle after the previous result has been
// loaded.
module breakpoint_watchpoint_table import bwt_pkg::*; #(
    parameter int TABLE_ENTRIES = 32,
    parameter int ADDRESS_BITS  = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // op[2:0], address[22:3], watch_kind[24:23], slot[30:25], zero[31]
    input  logic [31:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status[2:0], found_index[7:3], exec_word[71:8], read_word[135:72],
    // write_word[199:136], read_exec_word[263:200], read_summary[327:264],
    // write_summary[391:328]
    output logic [391:0] o_m_tdata
);

    t_cmd        cmd;
    t_dec        dec;
    logic        clr_done;
    logic [2:0]  status;
    logic [4:0]  found_index;
    logic [63:0] exec_word, read_word, write_word, read_exec_word;
    logic [63:0] read_summary, write_summary;

    bwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_clr_done (clr_done),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid)
    );

    bwt_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_s_tdata[2:0]),
        .i_address    (i_s_tdata[22:3]),
        .i_watch_kind (i_s_tdata[24:23]),
        .i_slot       (i_s_tdata[30:25]),
        .o_dec        (dec)
    );

    bwt_bitmap #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_bitmap (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_dec            (dec),
        .o_clr_done       (clr_done),
        .o_status         (status),
        .o_found_index    (found_index),
        .o_exec_word      (exec_word),
        .o_read_word      (read_word),
        .o_write_word     (write_word),
        .o_read_exec_word (read_exec_word),
        .o_read_summary   (read_summary),
        .o_write_summary  (write_summary)
    );

    assign o_m_tdata = {write_summary, read_summary, read_exec_word, write_word,
                        read_word, exec_word, found_index, status};

endmodule

### src/bwt_checker.sv
// Port-level checks for the breakpoint and watchpoint table, bound to the top level.
module bwt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [31:0]  i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [391:0] o_m_tdata
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] != 3'd0) |-> (o_m_tdata[7:3] == 5'd0))
        else $error("index reported with a failing status");

    a_or_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[263:200] == (o_m_tdata[71:8] | o_m_tdata[135:72])))
        else $error("combined read and exec word mismatch");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while another is in progress");

endmodule

bind breakpoint_watchpoint_table bwt_checker u_bwt_checker (.*);

### bench/breakpoint_watchpoint_table_test.sv
// Self-checking testbench for the breakpoint and watchpoint table against a predictor.
module breakpoint_watchpoint_table_test;
    import bwt_pkg::*;

    localparam int ENTRIES = 32;
    localparam int LIMIT   = 100000;

    typedef struct packed {
        logic [63:0] write_sum;
        logic [63:0] read_sum;
        logic [63:0] read_exec_w;
        logic [63:0] write_w;
        logic [63:0] read_w;
        logic [63:0] exec_w;
        logic [4:0]  index;
        logic [2:0]  status;
    } t_reply;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [31:0]  i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [391:0] o_m_tdata;

    logic [19:0] bp_addr [ENTRIES];
    logic        bp_on   [ENTRIES];
    int          bp_fill;
    logic [19:0] wp_addr [ENTRIES];
    logic [1:0]  wp_kind [ENTRIES];
    logic        wp_on   [ENTRIES];
    int          wp_fill;
    logic [63:0] exec_map  [logic [13:0]];
    logic [63:0] read_map  [logic [13:0]];
    logic [63:0] write_map [logic [13:0]];
    logic [63:0] read_page  [logic [7:0]];
    logic [63:0] write_page [logic [7:0]];

    t_reply expected_replies [$];
    int     mismatches;
    int     replies_seen;
    int     idle_cycles;
    bit     quiet;
    logic [19:0] recent [$];

    breakpoint_watchpoint_table dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] map_get(ref logic [63:0] m [logic [13:0]],
                                            input logic [13:0] w);
        return m.exists(w) ? m[w] : 64'd0;
    endfunction

    function automatic logic [63:0] page_get(ref logic [63:0] m [logic [7:0]],
                                             input logic [7:0] p);
        return m.exists(p) ? m[p] : 64'd0;
    endfunction

    function automatic void mark_bit(ref logic [63:0] m [logic [13:0]],
                                     ref logic [63:0] pg [logic [7:0]],
                                     input logic [19:0] a, input bit on, input bit has_page);
        logic [63:0] word;
        logic [63:0] sum;
        word = map_get(m, a[19:6]);
        sum  = page_get(pg, a[19:12]);
        if (on) begin
            word[a[5:0]] = 1'b1;
            sum[a[11:6]] = 1'b1;
        end else begin
            word[a[5:0]] = 1'b0;
            if (word == 0) sum[a[11:6]] = 1'b0;
        end
        m[a[19:6]] = word;
        if (has_page) pg[a[19:12]] = sum;
    endfunction

    function automatic void switch_bp(int s, bit on);
        logic [63:0] dummy [logic [7:0]];
        bp_on[s] = on;
        mark_bit(exec_map, dummy, bp_addr[s], on, 1'b0);
    endfunction

    function automatic void switch_wp(int s, bit on);
        wp_on[s] = on;
        if (wp_kind[s][0]) mark_bit(read_map, read_page, wp_addr[s], on, 1'b1);
        if (wp_kind[s][1]) mark_bit(write_map, write_page, wp_addr[s], on, 1'b1);
    endfunction

    function automatic int search_bp(logic [19:0] a);
        for (int i = bp_fill - 1; i >= 0; i--)
            if (bp_on[i] && bp_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic int search_wp(logic [19:0] a, logic [1:0] k);
        for (int i = wp_fill - 1; i >= 0; i--)
            if (wp_on[i] && wp_addr[i] == a && (wp_kind[i] & k) == k) return i;
        return -1;
    endfunction

    function automatic t_reply table_update(logic [2:0] op, logic [19:0] a, logic [1:0] k,
                                            logic [5:0] slot);
        t_reply r;
        logic [19:0] rep;
        int f;
        int s;
        r = '0;
        rep = a;
        s = int'(slot[4:0]);
        r.status = ST_OK;
        case (op)
            OP_ADD_BP: begin
                if (bp_fill >= ENTRIES) r.status = ST_FULL;
                else if (search_bp(a) >= 0) r.status = ST_PRESENT;
                else begin
                    r.index = 5'(bp_fill);
                    bp_addr[bp_fill] = a;
                    bp_fill++;
                    switch_bp(bp_fill - 1, 1'b1);
                end
            end
            OP_ADD_WP: begin
                if (wp_fill >= ENTRIES) r.status = ST_FULL;
                else if (search_wp(a, KIND_RW) >= 0) r.status = ST_PRESENT;
                else begin
                    r.index = 5'(wp_fill);
                    wp_addr[wp_fill] = a;
                    wp_kind[wp_fill] = k;
                    wp_fill++;
                    switch_wp(wp_fill - 1, 1'b1);
                end
            end
            OP_FIND_BP, OP_FIND_WP: begin
                f = (op == OP_FIND_BP) ? search_bp(a) : search_wp(a, k);
                if (f < 0) r.status = ST_NOT_FOUND;
                else r.index = 5'(f);
            end
            default: begin
                if (slot[5]) r.status = ST_IGNORED;
                else if (op == OP_BP_ON || op == OP_BP_OFF) begin
                    if (s >= bp_fill) r.status = ST_NOT_FOUND;
                    else begin
                        switch_bp(s, op == OP_BP_ON);
                        rep = bp_addr[s];
                        r.index = 5'(s);
                    end
                end else begin
                    if (s >= wp_fill) r.status = ST_NOT_FOUND;
                    else begin
                        switch_wp(s, op == OP_WP_ON);
                        rep = wp_addr[s];
                        r.index = 5'(s);
                    end
                end
            end
        endcase
        r.exec_w      = map_get(exec_map, rep[19:6]);
        r.read_w      = map_get(read_map, rep[19:6]);
        r.write_w     = map_get(write_map, rep[19:6]);
        r.read_exec_w = r.exec_w | r.read_w;
        r.read_sum    = page_get(read_page, rep[19:12]);
        r.write_sum   = page_get(write_page, rep[19:12]);
        return r;
    endfunction

    task automatic send_request(logic [2:0] op, logic [19:0] a, logic [1:0] k, logic [5:0] slot);
        int gap;
        if (!quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(4, 1);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, slot, k, a, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_replies.push_back(table_update(op, a, k, slot));
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            replies_seen++;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status || got.index !== want.index ||
                    got.exec_w !== want.exec_w || got.read_w !== want.read_w ||
                    got.write_w !== want.write_w || got.read_exec_w !== want.read_exec_w ||
                    got.read_sum !== want.read_sum || got.write_sum !== want.write_sum) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h, got %h", want, got);
                end
            end
        end
    end

    int stall_left;
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) i_m_tready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(4) == 0) begin
            stall_left <= $urandom_range(3);
            i_m_tready <= 1'b0;
        end else i_m_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [19:0] pick_address();
        if (recent.size() > 0 && $urandom_range(2) != 0)
            return recent[$urandom_range(recent.size() - 1)];
        return $urandom_range(3) == 0 ? 20'($urandom) : {12'h5a3, 2'($urandom), 6'($urandom)};
    endfunction

    task automatic test_adds_and_finds();
        send_request(OP_FIND_BP, 20'h00000, 2'd1, 6'd0);
        send_request(OP_ADD_BP, 20'h00000, 2'd0, 6'd0);
        send_request(OP_ADD_BP, 20'hfffff, 2'd0, 6'd0);
        send_request(OP_ADD_BP, 20'hfffff, 2'd0, 6'd0);
        send_request(OP_ADD_WP, 20'hfffff, 2'd3, 6'd0);
        send_request(OP_ADD_WP, 20'hfffff, 2'd1, 6'd0);
        send_request(OP_ADD_WP, 20'hffffe, 2'd2, 6'd0);
        send_request(OP_ADD_WP, 20'h12345, 2'd0, 6'd0);
        send_request(OP_FIND_WP, 20'h12345, 2'd0, 6'd0);
        send_request(OP_FIND_WP, 20'hfffff, 2'd3, 6'd0);
        send_request(OP_FIND_WP, 20'hffffe, 2'd1, 6'd0);
        send_request(OP_FIND_BP, 20'hfffff, 2'd3, 6'd0);
    endtask

    task automatic test_switching();
        send_request(OP_BP_OFF, 20'h0, 2'd0, 6'd1);
        send_request(OP_BP_OFF, 20'h0, 2'd0, 6'd1);
        send_request(OP_BP_ON, 20'h0, 2'd0, 6'd1);
        send_request(OP_WP_OFF, 20'h0, 2'd0, 6'd1);
        send_request(OP_WP_ON, 20'h0, 2'd0, 6'd2);
        send_request(OP_WP_OFF, 20'h0, 2'd0, 6'd31);
        send_request(OP_BP_ON, 20'h0, 2'd0, 6'h3f);
        send_request(OP_WP_ON, 20'h0, 2'd0, 6'h20);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < 34; i++) begin
            send_request(OP_ADD_BP, 20'(20'h40000 + i), 2'd0, 6'd0);
            send_request(OP_ADD_WP, 20'(20'h40000 + i), 2'(1 + i % 3), 6'd0);
        end
    endtask

    task automatic test_random(int count);
        logic [2:0]  op;
        logic [19:0] a;
        for (int i = 0; i < count; i++) begin
            if (i == count - 150) quiet = 1'b1;
            op = 3'($urandom);
            a = pick_address();
            if (op <= OP_ADD_WP && recent.size() < 64) recent.push_back(a);
            send_request(op, a, 2'($urandom), $urandom_range(9) == 0 ? 6'($urandom) :
                         6'($urandom_range(31)));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        mismatches = 0;
        replies_seen = 0;
        quiet = 1'b0;
        bp_fill = 0;
        wp_fill = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            bp_addr[i] = '0; bp_on[i] = 0; wp_addr[i] = '0; wp_kind[i] = '0; wp_on[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_adds_and_finds();
        test_switching();
        test_table_full();
        test_random(1350);
        i_s_tvalid <= 1'b0;
        while (expected_replies.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d results: table fill and overflow, lookups, switching of slots,",
                 replies_seen);
        $display("ignored and out-of-range slots, with random gaps and back-pressure.");
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### files.f
src/bwt_pkg.sv
src/bwt_ctrl.sv
src/bwt_table.sv
src/bwt_bitmap.sv
src/breakpoint_watchpoint_table.sv
src/bwt_checker.sv
bench/breakpoint_watchpoint_table_test.sv
